@@ rtl/core/es2d_pkg.sv @@
// ----------------------------------------------------------------------------
// es2d_pkg
// Types, constants and the microprogram of the seconds-to-date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package es2d_pkg;

	localparam int unsigned SECS_W   = 32;
	localparam int unsigned YEAR_W   = 12;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned SECOND_W = 6;

	// Whole days since the epoch fit in 16 bits for any 32-bit count.
	localparam int unsigned DAYS_W    = 16;
	// Seconds of the day, and seconds left within the hour.
	localparam int unsigned TOD_W     = 17;
	localparam int unsigned MIN_REM_W = 12;
	localparam int unsigned PC_W      = 4;
	localparam int unsigned PROG_LEN  = 11;

	localparam logic [TOD_W-1:0]    SECS_PER_DAY  = 17'd86400;
	localparam logic [TOD_W-1:0]    SECS_PER_HOUR = 17'd3600;
	localparam logic [SECOND_W-1:0] SECS_PER_MIN  = 6'd60;

	// Each quotient is the top bits of the dividend, shifted right by the
	// divisor's power of two, times a rounded-up reciprocal of the odd part.
	// The reciprocals are exact over the full range each dividend can take.
	localparam int unsigned DAY_PRE     = 7;
	localparam int unsigned DAY_PROD_W  = 51;
	localparam logic [25:0] DAY_RECIP   = 26'd50903317;
	localparam int unsigned HOUR_PRE    = 4;
	localparam int unsigned HOUR_PROD_W = 26;
	localparam logic [13:0] HOUR_RECIP  = 14'd9321;
	localparam int unsigned MIN_PRE     = 2;
	localparam int unsigned MIN_PROD_W  = 20;
	localparam logic [10:0] MIN_RECIP   = 11'd1093;

	localparam logic [YEAR_W-1:0]  BASE_YEAR   = 12'd1970;
	localparam logic [1:0]         BASE_MOD4   = 2'd2;
	localparam logic [6:0]         BASE_MOD100 = 7'd70;
	localparam logic [8:0]         BASE_MOD400 = 9'd370;
	localparam logic [6:0]         LAST_MOD100 = 7'd99;
	localparam logic [8:0]         LAST_MOD400 = 9'd399;
	localparam logic [8:0]         LEAP_YEAR_DAYS = 9'd366;
	localparam logic [8:0]         YEAR_DAYS      = 9'd365;
	localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
	localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd2;
	localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DAYS,
		OP_TOD,
		OP_HOUR,
		OP_MIN_REM,
		OP_MINUTE,
		OP_SECOND,
		OP_YEAR,
		OP_MONTH,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_LOOP,
		COND_GOTO
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} cw_t;

	localparam cw_t UCODE [PROG_LEN] = '{
		'{op: OP_LOAD,    cond: COND_LOOP, target: 4'd0},
		'{op: OP_DAYS,    cond: COND_NEXT, target: 4'd0},
		'{op: OP_TOD,     cond: COND_NEXT, target: 4'd0},
		'{op: OP_HOUR,    cond: COND_NEXT, target: 4'd0},
		'{op: OP_MIN_REM, cond: COND_NEXT, target: 4'd0},
		'{op: OP_MINUTE,  cond: COND_NEXT, target: 4'd0},
		'{op: OP_SECOND,  cond: COND_NEXT, target: 4'd0},
		'{op: OP_YEAR,    cond: COND_LOOP, target: 4'd7},
		'{op: OP_MONTH,   cond: COND_LOOP, target: 4'd8},
		'{op: OP_EMIT,    cond: COND_LOOP, target: 4'd9},
		'{op: OP_NOP,     cond: COND_GOTO, target: 4'd0}
	};

	function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m, input logic leap);
		logic [4:0] v;
		case (m)
			FEBRUARY:                        v = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:         v = 5'd30;
			default:                         v = 5'd31;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/es2d_seq.sv @@
// ----------------------------------------------------------------------------
// es2d_seq
// Step counter and microcode ROM; picks the next step from the jump condition.
// ----------------------------------------------------------------------------
`default_nettype none

module es2d_seq
	import es2d_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  stay,
	output cw_t  cw
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;

	assign cw = UCODE[pc_q];

	always_comb begin
		unique case (cw.cond)
			COND_NEXT: pc_next = pc_q + 1'b1;
			COND_LOOP: pc_next = stay ? cw.target : pc_q + 1'b1;
			COND_GOTO: pc_next = cw.target;
			default:   pc_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_next;
		end
	end

`ifndef SYNTHESIS
	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q < PC_W'(PROG_LEN))
		else $error("step counter left the microprogram");

	a_goto_returns_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		cw.cond == COND_GOTO |=> cw.op == OP_LOAD)
		else $error("end of program did not return to load step");
`endif

endmodule

`default_nettype wire

@@ rtl/core/es2d_datapath.sv @@
// ----------------------------------------------------------------------------
// es2d_datapath
// Reciprocal-multiply splitting, year and month removal, and the result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module es2d_datapath
	import es2d_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  cw_t                  cw,
	output logic                 stay,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire [SECS_W-1:0]     epoch_seconds,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [YEAR_W-1:0]    year,
	output logic [MONTH_W-1:0]   month,
	output logic [DAY_W-1:0]     day,
	output logic [HOUR_W-1:0]    hour,
	output logic [MINUTE_W-1:0]  minute,
	output logic [SECOND_W-1:0]  second
);

	logic [SECS_W-1:0]   rem_q;
	logic [DAYS_W-1:0]   days_q;
	logic [YEAR_W-1:0]   year_q;
	logic [1:0]          mod4_q;
	logic [6:0]          mod100_q;
	logic [8:0]          mod400_q;
	logic [MONTH_W-1:0]  month_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [MINUTE_W-1:0] minute_q;
	logic [SECOND_W-1:0] second_q;

	logic [DAY_PROD_W-1:0]  day_prod;
	logic [SECS_W-1:0]      day_secs;
	logic [HOUR_PROD_W-1:0] hour_prod;
	logic [TOD_W-1:0]       hour_secs;
	logic [MIN_PROD_W-1:0]  min_prod;
	logic [SECOND_W-1:0]    min_secs_lo;
	logic                   leap;
	logic [8:0]             ylen;
	logic [4:0]             mlen;
	logic                   year_fit;
	logic                   month_fit;

	// Each product is read in its own step, one multiply per step.
	assign day_prod    = DAY_PROD_W'(rem_q[SECS_W-1:DAY_PRE]) * DAY_PROD_W'(DAY_RECIP);
	assign day_secs    = SECS_W'(days_q) * SECS_W'(SECS_PER_DAY);
	assign hour_prod   = HOUR_PROD_W'(rem_q[TOD_W-1:HOUR_PRE]) * HOUR_PROD_W'(HOUR_RECIP);
	assign hour_secs   = TOD_W'(hour_q) * SECS_PER_HOUR;
	assign min_prod    = MIN_PROD_W'(rem_q[MIN_REM_W-1:MIN_PRE]) * MIN_PROD_W'(MIN_RECIP);
	// The seconds are below 64, so the low bits of the difference suffice.
	assign min_secs_lo = minute_q * SECS_PER_MIN;

	assign leap      = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
	assign ylen      = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
	assign mlen      = month_days(month_q, leap);
	assign year_fit  = days_q >= {{(DAYS_W-9){1'b0}}, ylen};
	assign month_fit = (month_q != LAST_MONTH) && (days_q >= {{(DAYS_W-5){1'b0}}, mlen});

	assign in_ready  = cw.op == OP_LOAD;
	assign out_valid = cw.op == OP_EMIT;

	always_comb begin
		case (cw.op)
			OP_LOAD:  stay = !in_valid;
			OP_YEAR:  stay = year_fit;
			OP_MONTH: stay = month_fit;
			OP_EMIT:  stay = !out_ready;
			default:  stay = 1'b0;
		endcase
	end

	// The year and its leap trackers, which must agree after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q   <= BASE_YEAR;
			mod4_q   <= BASE_MOD4;
			mod100_q <= BASE_MOD100;
			mod400_q <= BASE_MOD400;
		end else begin
			case (cw.op)
				OP_LOAD: begin
					year_q   <= BASE_YEAR;
					mod4_q   <= BASE_MOD4;
					mod100_q <= BASE_MOD100;
					mod400_q <= BASE_MOD400;
				end
				OP_YEAR: begin
					if (year_fit) begin
						year_q   <= year_q + 1'b1;
						mod4_q   <= mod4_q + 1'b1;
						mod100_q <= (mod100_q == LAST_MOD100) ? 7'd0 : mod100_q + 1'b1;
						mod400_q <= (mod400_q == LAST_MOD400) ? 9'd0 : mod400_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			OP_LOAD: begin
				rem_q   <= epoch_seconds;
				month_q <= FIRST_MONTH;
			end
			OP_DAYS: begin
				days_q <= day_prod[DAY_PROD_W-1 -: DAYS_W];
			end
			OP_TOD: begin
				rem_q <= rem_q - day_secs;
			end
			OP_HOUR: begin
				hour_q <= hour_prod[HOUR_PROD_W-1 -: HOUR_W];
			end
			OP_MIN_REM: begin
				rem_q <= rem_q - SECS_W'(hour_secs);
			end
			OP_MINUTE: begin
				minute_q <= min_prod[MIN_PROD_W-1 -: MINUTE_W];
			end
			OP_SECOND: begin
				second_q <= rem_q[SECOND_W-1:0] - min_secs_lo;
			end
			OP_YEAR: begin
				if (year_fit) begin
					days_q <= days_q - {{(DAYS_W-9){1'b0}}, ylen};
				end
			end
			OP_MONTH: begin
				if (month_fit) begin
					days_q  <= days_q - {{(DAYS_W-5){1'b0}}, mlen};
					month_q <= month_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign year   = year_q;
	assign month  = month_q;
	assign day    = days_q[DAY_W-1:0] + 1'b1;
	assign hour   = hour_q;
	assign minute = minute_q;
	assign second = second_q;

`ifndef SYNTHESIS
	a_mod4_tracks_year: assert property (@(posedge clk) disable iff (!arst_n)
		mod4_q == year_q[1:0])
		else $error("leap tracker out of step with the year");

	a_tod_in_day: assert property (@(posedge clk) disable iff (!arst_n)
		cw.op == OP_HOUR |-> rem_q < SECS_W'(SECS_PER_DAY))
		else $error("time of day not below one day");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_q >= FIRST_MONTH) && (month_q <= LAST_MONTH))
		else $error("month out of range at result");

	a_day_fits_month: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> days_q < {{(DAYS_W-5){1'b0}}, mlen})
		else $error("day remainder exceeds the month length");
`endif

endmodule

`default_nettype wire

@@ rtl/core/epoch_seconds_to_date.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_date
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 to a
// Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_ready, epoch_seconds) takes one
// transaction while the block is waiting at its load step; in_ready is low
// at all other times. The result (year, month, day, hour, minute, second)
// is offered on the output channel (out_valid, out_ready) and held until
// the receiver takes the transaction; a stalled receiver simply keeps the
// block at its emit step. One item is converted at a time.
// After the input transaction the microcoded sequencer spends six single
// steps on days, time of day, hour, minutes and seconds by reciprocal
// multiplication, then removes one year per step (0 to 136 years) and
// one month per step (0 to 11 months), leaving each loop at the step on
// which nothing more fits. After the output transaction, a no-op step
// returns the sequencer to the load step before in_ready rises again.
// Reset puts the step counter at the load step; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_date
	import es2d_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire [SECS_W-1:0]     epoch_seconds,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [YEAR_W-1:0]    year,
	output logic [MONTH_W-1:0]   month,
	output logic [DAY_W-1:0]     day,
	output logic [HOUR_W-1:0]    hour,
	output logic [MINUTE_W-1:0]  minute,
	output logic [SECOND_W-1:0]  second
);

	cw_t  cw;
	logic stay;

	es2d_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stay   (stay),
		.cw     (cw)
	);

	es2d_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cw            (cw),
		.stay          (stay),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.epoch_seconds (epoch_seconds),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second)
	);

endmodule

`default_nettype wire

@@ verif/date_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_checker
// Watches both channels of the seconds-to-date converter, works out the
// calendar date for every accepted input and compares each output
// transaction, field by field, with the oldest date still outstanding.
// ----------------------------------------------------------------------------

module date_checker
	import es2d_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [SECS_W-1:0]   epoch_seconds,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [YEAR_W-1:0]   year,
	input  logic [MONTH_W-1:0]  month,
	input  logic [DAY_W-1:0]    day,
	input  logic [HOUR_W-1:0]   hour,
	input  logic [MINUTE_W-1:0] minute,
	input  logic [SECOND_W-1:0] second,
	output int                  outstanding,
	output int                  mismatches
);

	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned SECS_PER_HOUR = 3600;
	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned EPOCH_YEAR    = 1970;
	localparam int unsigned DAYS_IN_MONTH [0:11] = '{31, 28, 31, 30, 31, 30,
		31, 31, 30, 31, 30, 31};

	typedef struct {
		logic [SECS_W-1:0]   secs;
		logic [YEAR_W-1:0]   yr;
		logic [MONTH_W-1:0]  mon;
		logic [DAY_W-1:0]    dom;
		logic [HOUR_W-1:0]   hr;
		logic [MINUTE_W-1:0] mins;
		logic [SECOND_W-1:0] sec;
	} date_t;

	date_t expected_dates [$];
	date_t want;
	int    mismatch_count = 0;

	assign mismatches = mismatch_count;

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic date_t calendar_of(input logic [SECS_W-1:0] secs);
		int unsigned days;
		int unsigned tod;
		int unsigned yr;
		int unsigned mon;
		int unsigned mlen;
		date_t d;
		days = secs / SECS_PER_DAY;
		tod  = secs % SECS_PER_DAY;
		yr   = EPOCH_YEAR;
		while (days >= (leap_year(yr) ? 366 : 365)) begin
			days -= leap_year(yr) ? 366 : 365;
			yr++;
		end
		// The leftover days are always less than a year, so December absorbs
		// whatever remains after November.
		mon = 1;
		while (mon < 12) begin
			mlen = (mon == 2 && leap_year(yr)) ? 29 : DAYS_IN_MONTH[mon-1];
			if (days < mlen)
				break;
			days -= mlen;
			mon++;
		end
		d.secs = secs;
		d.yr   = yr[YEAR_W-1:0];
		d.mon  = mon[MONTH_W-1:0];
		d.dom  = DAY_W'(days + 1);
		d.hr   = HOUR_W'((tod / SECS_PER_HOUR) % 24);
		d.mins = MINUTE_W'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
		d.sec  = SECOND_W'(tod % SECS_PER_MIN);
		return d;
	endfunction

	task automatic report_mismatch(input string what, input logic [SECS_W-1:0] secs,
		input int got, input int exp_val);
		$display("date_checker: %0t: %s for seconds %0d: got %0d, expected %0d",
			$realtime, what, secs, got, exp_val);
		mismatch_count++;
	endtask

	// Outputs are checked before the input of the same edge is queued, so a
	// result never meets the date of the transaction taken alongside it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_dates.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					report_mismatch("result with no date outstanding", '0, year, 0);
				end else begin
					want = expected_dates.pop_front();
					if (year !== want.yr)
						report_mismatch("year", want.secs, year, want.yr);
					if (month !== want.mon)
						report_mismatch("month", want.secs, month, want.mon);
					if (day !== want.dom)
						report_mismatch("day", want.secs, day, want.dom);
					if (hour !== want.hr)
						report_mismatch("hour", want.secs, hour, want.hr);
					if (minute !== want.mins)
						report_mismatch("minute", want.secs, minute, want.mins);
					if (second !== want.sec)
						report_mismatch("second", want.secs, second, want.sec);
				end
			end
			if (in_valid && in_ready)
				expected_dates.push_back(calendar_of(epoch_seconds));
			outstanding <= expected_dates.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the seconds-to-date converter with directed calendar corners and
// then random counts, biased toward year and month boundaries, under random
// sender bursts and receiver stalls; date_checker judges every result.
// ----------------------------------------------------------------------------

module tb_top;

	import es2d_pkg::*;

	localparam int N_ITEMS     = 1850;
	localparam int DRAIN_AT    = 1200;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 600;
	localparam int END_CYCLES  = 200;
	localparam int STALL_LIMIT = 5000;
	localparam int N_DIRECTED  = 21;

	localparam logic [SECS_W-1:0] DIRECTED [0:N_DIRECTED-1] = '{
		32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
		32'd31535999,   // last second of 1970
		32'd68169600,   // leap day 1972
		32'd94694399,   // last second of leap year 1972
		32'd94694400,
		32'd951782400,  // leap day 2000, a century divisible by 400
		32'd978307199,
		32'd4107542399, // 2100-02-28, a century that is not a leap year
		32'd4107542400,
		32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
		32'hFFFF_FFFF
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [SECS_W-1:0]   epoch_seconds = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic [DAY_W-1:0]    day;
	logic [HOUR_W-1:0]   hour;
	logic [MINUTE_W-1:0] minute;
	logic [SECOND_W-1:0] second;

	int outstanding;
	int mismatches;
	int n_sent = 0;
	int n_accepted = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	epoch_seconds_to_date uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.epoch_seconds (epoch_seconds),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second)
	);

	date_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.epoch_seconds (epoch_seconds),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.outstanding   (outstanding),
		.mismatches    (mismatches)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				n_accepted <= n_accepted + 1;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Offers one transaction and holds it until taken. Valid stays high into
	// the next transaction within a burst; a gap is never empty, so valid is
	// never dropped and raised in the same step.
	task automatic send_item(input logic [SECS_W-1:0] value);
		in_valid      <= 1'b1;
		epoch_seconds <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
		if (n_sent == DRAIN_AT) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (outstanding != 0)
				@(posedge clk);
		end else if (n_sent == N_ITEMS) begin
			in_valid <= 1'b0;
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 9) < 7)
				repeat ($urandom_range(1, 10)) @(posedge clk);
			else
				repeat ($urandom_range(1, 250)) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// Receiver: switches among stall patterns of random length, and once,
	// after some traffic, refuses results long enough to back up the input.
	initial begin
		int  mode;
		int  len;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && n_accepted >= HOLD_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				len  = $urandom_range(20, 300);
				repeat (len) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= $urandom_range(0, 1);
						2: out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= ~out_ready;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		int unsigned days;
		int unsigned tod;
		int unsigned y;
		int unsigned m;
		int unsigned k;
		logic [SECS_W-1:0] secs;
		@(posedge arst_n);
		@(posedge clk);
		burst_left = $urandom_range(0, 10);
		for (int i = 0; i < N_DIRECTED; i++)
			send_item(DIRECTED[i]);
		while (n_sent < N_ITEMS) begin
			k = $urandom_range(0, 99);
			if (k < 45) begin
				secs = $urandom;
			end else if (k < 80) begin
				// Land next to the start of a random month of a random year.
				y = $urandom_range(1970, 2105);
				m = $urandom_range(1, 12);
				days = 0;
				for (int unsigned yy = 1970; yy < y; yy++)
					days += (((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0))
						? 366 : 365;
				for (int unsigned mm = 1; mm < m; mm++) begin
					if (mm == 2)
						days += (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0))
							? 29 : 28;
					else if (mm == 4 || mm == 6 || mm == 9 || mm == 11)
						days += 30;
					else
						days += 31;
				end
				if (days > 0 && $urandom_range(0, 1) == 1)
					secs = days * 32'd86400 - 32'd1 - $urandom_range(0, 59);
				else
					secs = days * 32'd86400 + $urandom_range(0, 59);
			end else begin
				days = $urandom_range(0, 49709);
				case ($urandom_range(0, 3))
					0: tod = 0;
					1: tod = 86399;
					2: tod = 3600 * $urandom_range(0, 23) + 3599;
					default: tod = $urandom_range(0, 86399);
				endcase
				secs = days * 32'd86400 + tod;
			end
			send_item(secs);
		end
		// The checker counts the last transaction only after its edge.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
